/* hw/rtl/lsps_pkg.sv */
// Package for the line sensor PD steering block: register indexes, reset values,
// microcode word layout and the control store. No dependencies.
package lsps_pkg;

  localparam int SENSOR_COUNT_DEF = 8;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 8;

  // Register reset values
  localparam logic [7:0] BASE_SPEED_RST     = 8'd90;
  localparam logic [7:0] FALLBACK_LEFT_RST  = 8'd76;
  localparam logic [7:0] FALLBACK_RIGHT_RST = 8'd60;
  localparam logic [7:0] P_GAIN_RST         = 8'd4;
  localparam logic [7:0] D_GAIN_RST         = 8'd40;
  localparam logic [6:0] SETPOINT_RST       = 7'd35;
  localparam logic [7:0] HOLD_THRESH_RST    = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_SPEED     = 3'd0,
    CFG_FALLBACK_LEFT  = 3'd1,
    CFG_FALLBACK_RIGHT = 3'd2,
    CFG_P_GAIN         = 3'd3,
    CFG_D_GAIN         = 3'd4,
    CFG_SETPOINT       = 3'd5,
    CFG_HOLD_THRESH    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CROSS_ERROR = 2'd0,
    CROSS_T     = 2'd1,
    CROSS_RIGHT = 2'd2,
    CROSS_LEFT  = 2'd3
  } cross_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCAN,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_HOLD,
    OP_ERR,
    OP_MUL_D,
    OP_MUL_P,
    OP_EMIT
  } op_e;

  // Sequencer conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_SCAN_MORE,
    COND_NO_LINE,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t PC_LOAD = 4'd0;
  localparam upc_t PC_SCAN = 4'd1;
  localparam upc_t PC_DINI = 4'd2;
  localparam upc_t PC_DIV  = 4'd3;
  localparam upc_t PC_HOLD = 4'd4;
  localparam upc_t PC_ERR  = 4'd5;
  localparam upc_t PC_MULD = 4'd6;
  localparam upc_t PC_MULP = 4'd7;
  localparam upc_t PC_EMIT = 4'd8;

  // wait_cond: stay on this step while true; else br_cond selects br_target or pc+1
  typedef struct packed {
    op_e   op;
    cond_e wait_cond;
    cond_e br_cond;
    upc_t  br_target;
  } ucode_t;

  typedef struct packed {
    logic no_in;
    logic scan_more;
    logic no_line;
    logic div_more;
    logic out_busy;
  } cond_t;

  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    unique case (pc)
      PC_LOAD: w = '{OP_LOAD,     COND_NO_IN,     COND_NEVER,   PC_LOAD};
      PC_SCAN: w = '{OP_SCAN,     COND_SCAN_MORE, COND_NEVER,   PC_LOAD};
      PC_DINI: w = '{OP_DIV_INIT, COND_NEVER,     COND_NO_LINE, PC_ERR};
      PC_DIV:  w = '{OP_DIV_STEP, COND_DIV_MORE,  COND_NEVER,   PC_LOAD};
      PC_HOLD: w = '{OP_HOLD,     COND_NEVER,     COND_NEVER,   PC_LOAD};
      PC_ERR:  w = '{OP_ERR,      COND_NEVER,     COND_NEVER,   PC_LOAD};
      PC_MULD: w = '{OP_MUL_D,    COND_NEVER,     COND_NEVER,   PC_LOAD};
      PC_MULP: w = '{OP_MUL_P,    COND_NEVER,     COND_NEVER,   PC_LOAD};
      PC_EMIT: w = '{OP_EMIT,     COND_OUT_BUSY,  COND_ALWAYS,  PC_LOAD};
      default: w = '{OP_NOP,      COND_NEVER,     COND_ALWAYS,  PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/lsps_if.sv */
// Valid/ready channel interfaces for sensor rows and steering results.
// Standalone; no package dependency.
interface lsps_sensor_if #(
  parameter int N = 8
);
  logic         valid;
  logic         ready;
  logic [N-1:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface lsps_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic        [2:0]  line_count;
  logic        [6:0]  first_line_position;
  logic        [1:0]  cross_type;
  logic               on_track;

  modport source (output valid, output left_speed, output right_speed, output line_count,
                  output first_line_position, output cross_type, output on_track,
                  input ready);
  modport sink   (input valid, input left_speed, input right_speed, input line_count,
                  input first_line_position, input cross_type, input on_track,
                  output ready);
endinterface

/* hw/rtl/lsps_useq.sv */
// Microcode sequencer: step counter, control store lookup, wait and branch logic.
// Depends on lsps_pkg.
module lsps_useq
  import lsps_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cond_t  cond_i,
  output ucode_t cw_o
);

  upc_t pc_q, pc_d;
  logic wait_hit, br_hit;

  function automatic logic eval(input cond_e c, input cond_t f);
    logic r;
    unique case (c)
      COND_NEVER:     r = 1'b0;
      COND_ALWAYS:    r = 1'b1;
      COND_NO_IN:     r = f.no_in;
      COND_SCAN_MORE: r = f.scan_more;
      COND_NO_LINE:   r = f.no_line;
      COND_DIV_MORE:  r = f.div_more;
      COND_OUT_BUSY:  r = f.out_busy;
      default:        r = 1'b0;
    endcase
    return r;
  endfunction

  assign cw_o     = ucode_rom(pc_q);
  assign wait_hit = eval(cw_o.wait_cond, cond_i);
  assign br_hit   = eval(cw_o.br_cond, cond_i);

  always_comb begin
    if (wait_hit) begin
      pc_d = pc_q;
    end else if (br_hit) begin
      pc_d = cw_o.br_target;
    end else begin
      pc_d = pc_q + upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* hw/rtl/line_sensor_pd_steering_core.sv */
// Top level of the line sensor PD steering block: datapath, config registers,
// result register. Depends on lsps_pkg, lsps_if.sv and lsps_useq.
//
// One sensor row is taken per transfer and turned into one result. The work is
// driven by a small microprogram: take the row, walk it bit by bit to one past
// the top sensor (counting runs, keeping the lowest run's index sum and
// length), set up the centroid division, run restoring division over DVD_W
// quotient bits (one quotient bit a cycle; DVD_W is 9 for eight sensors),
// clamp and hold the position, then error, D product, P product and result
// write. A row with no line skips the division and the hold step. The bit
// walk and the serial divider take the most time; one shared 9x9 multiplier
// serves both gain terms.
// A finished result sits in the output register while the next row is taken;
// the result write step waits only if that register is still full.
// Configuration is a plain write port, index per the register list; unknown
// indexes are dropped.
module line_sensor_pd_steering_core
  import lsps_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  lsps_sensor_if.sink           sensor_i,
  lsps_result_if.source         result_o
);

  localparam int IDX_W   = $clog2(SENSOR_COUNT + 1);
  localparam int LEN_W   = $clog2(SENSOR_COUNT + 1);
  localparam int SUM_MAX = SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int DVD_W   = $clog2(10 * SUM_MAX + 1);
  localparam int DCNT_W  = $clog2(DVD_W);
  localparam int QX_W    = (DVD_W > 7) ? DVD_W : 7;

  // ---------------- configuration registers ----------------
  logic [7:0] base_speed_q, fb_left_q, fb_right_q, p_gain_q, d_gain_q, thresh_q;
  logic [6:0] setpoint_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q <= BASE_SPEED_RST;
      fb_left_q    <= FALLBACK_LEFT_RST;
      fb_right_q   <= FALLBACK_RIGHT_RST;
      p_gain_q     <= P_GAIN_RST;
      d_gain_q     <= D_GAIN_RST;
      setpoint_q   <= SETPOINT_RST;
      thresh_q     <= HOLD_THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_SPEED:     base_speed_q <= cfg_wdata_i;
        CFG_FALLBACK_LEFT:  fb_left_q    <= cfg_wdata_i;
        CFG_FALLBACK_RIGHT: fb_right_q   <= cfg_wdata_i;
        CFG_P_GAIN:         p_gain_q     <= cfg_wdata_i;
        CFG_D_GAIN:         d_gain_q     <= cfg_wdata_i;
        CFG_SETPOINT:       setpoint_q   <= cfg_wdata_i[6:0];
        CFG_HOLD_THRESH:    thresh_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  ucode_t cw;
  cond_t  cond;

  lsps_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .cw_o   (cw)
  );

  // ---------------- datapath state ----------------
  logic [SENSOR_COUNT-1:0] bits_q;       // shifts right during the walk
  logic                    edge_lo_q, edge_hi_q;
  logic [IDX_W-1:0]        idx_q;
  logic [SUM_W-1:0]        run_sum_q, first_sum_q;
  logic [LEN_W-1:0]        run_len_q, first_len_q;
  logic [2:0]              runs_q;
  logic                    found_q;
  logic [LEN_W-1:0]        rem_q;
  logic [DVD_W-1:0]        quo_q;
  logic [DCNT_W-1:0]       div_cnt_q;
  logic signed [7:0]       err_q;
  logic signed [8:0]       diff_q;
  logic                    refresh_q;
  logic signed [15:0]      pterm_q;

  // persistent controller state
  logic [6:0]              held_pos_q;
  logic signed [7:0]       prev_err_q;
  logic signed [16:0]      held_d_q;
  logic [7:0]              step_cnt_q;

  // result register
  logic                    out_valid_q;
  logic signed [15:0]      left_q, right_q;
  logic [2:0]              count_q;
  logic [6:0]              pos_q;
  cross_e                  cross_q;
  logic                    track_q;

  logic in_xfer, out_busy;
  assign sensor_i.ready = (cw.op == OP_LOAD);
  assign in_xfer        = sensor_i.valid && sensor_i.ready;
  assign out_busy       = out_valid_q && !result_o.ready;

  assign cond.no_in     = !sensor_i.valid;
  assign cond.scan_more = (idx_q != IDX_W'(SENSOR_COUNT));
  assign cond.no_line   = !found_q;
  assign cond.div_more  = (div_cnt_q != '0);
  assign cond.out_busy  = out_busy;

  // ---------------- combinational datapath ----------------
  logic [DVD_W-1:0]       dividend;
  logic [LEN_W:0]         rem_shift;
  logic                   rem_ge;
  logic [QX_W-1:0]        quo_ext;
  logic signed [7:0]      err_d;
  logic signed [17:0]     mul_p;
  logic signed [17:0]     steer;
  logic signed [18:0]     left_w, right_w;
  logic                   one_line;
  cross_e                 cross_d;

  // sum*10 as shift-add
  assign dividend  = DVD_W'({first_sum_q, 3'b000}) + DVD_W'({first_sum_q, 1'b0});
  assign rem_shift = {rem_q, quo_q[DVD_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, first_len_q});
  assign quo_ext   = QX_W'(quo_q);

  assign err_d = $signed({1'b0, held_pos_q}) - $signed({1'b0, setpoint_q});

  // shared multiplier: D gain times error change, or P gain times error
  always_comb begin
    if (cw.op == OP_MUL_D) begin
      mul_p = 18'($signed({1'b0, d_gain_q})) * 18'(diff_q);
    end else begin
      mul_p = $signed({1'b0, p_gain_q}) * 18'(err_q);
    end
  end

  assign steer   = 18'(pterm_q) + 18'(held_d_q);
  assign left_w  = $signed({11'b0, base_speed_q}) - 19'(steer);
  assign right_w = $signed({11'b0, base_speed_q}) + 19'(steer);
  assign one_line = (runs_q == 3'd1);

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    cross_d = CROSS_ERROR;
    if (one_line) begin
      if (edge_lo_q && edge_hi_q) begin
        cross_d = CROSS_T;
      end else if (edge_lo_q) begin
        cross_d = CROSS_RIGHT;
      end else if (edge_hi_q) begin
        cross_d = CROSS_LEFT;
      end
    end
  end

  // ---------------- working registers (no reset needed) ----------------
  always_ff @(posedge clk_i) begin
    case (cw.op)
      OP_LOAD: begin
        if (in_xfer) begin
          bits_q    <= sensor_i.sensor_bits;
          edge_lo_q <= sensor_i.sensor_bits[0];
          edge_hi_q <= sensor_i.sensor_bits[SENSOR_COUNT-1];
          idx_q     <= '0;
          run_sum_q <= '0;
          run_len_q <= '0;
          runs_q    <= '0;
          found_q   <= 1'b0;
        end
      end
      OP_SCAN: begin
        bits_q <= bits_q >> 1;
        idx_q  <= idx_q + IDX_W'(1);
        if (bits_q[0]) begin
          run_sum_q <= run_sum_q + SUM_W'(idx_q);
          run_len_q <= run_len_q + LEN_W'(1);
        end else if (run_len_q != '0) begin
          if (!found_q) begin
            first_sum_q <= run_sum_q;
            first_len_q <= run_len_q;
            found_q     <= 1'b1;
          end
          if (runs_q != 3'd7) begin
            runs_q <= runs_q + 3'd1;
          end
          run_sum_q <= '0;
          run_len_q <= '0;
        end
      end
      OP_DIV_INIT: begin
        rem_q     <= '0;
        quo_q     <= dividend;
        div_cnt_q <= DCNT_W'(DVD_W - 1);
      end
      OP_DIV_STEP: begin
        rem_q     <= rem_ge ? LEN_W'(rem_shift - {1'b0, first_len_q}) : rem_shift[LEN_W-1:0];
        quo_q     <= {quo_q[DVD_W-2:0], rem_ge};
        div_cnt_q <= div_cnt_q - DCNT_W'(1);
      end
      OP_ERR: begin
        err_q     <= err_d;
        diff_q    <= 9'(err_d) - 9'(prev_err_q);
        refresh_q <= (step_cnt_q > thresh_q);
      end
      OP_MUL_P: begin
        pterm_q <= mul_p[15:0];
      end
      default: ;
    endcase
  end

  // ---------------- controller state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_pos_q <= '0;
      prev_err_q <= '0;
      held_d_q   <= '0;
      step_cnt_q <= '0;
    end else begin
      case (cw.op)
        OP_HOLD: begin
          held_pos_q <= (quo_ext > QX_W'(127)) ? 7'd127 : quo_ext[6:0];
        end
        OP_ERR: begin
          // counter wraps; cleared on refresh
          step_cnt_q <= (step_cnt_q > thresh_q) ? 8'd0 : step_cnt_q + 8'd1;
        end
        OP_MUL_D: begin
          if (refresh_q) begin
            held_d_q   <= mul_p[16:0];
            prev_err_q <= err_q;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cw.op == OP_EMIT && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.op == OP_EMIT && !out_busy) begin
      left_q  <= one_line ? sat16(left_w) : $signed({8'b0, fb_left_q});
      right_q <= one_line ? sat16(right_w) : $signed({8'b0, fb_right_q});
      count_q <= runs_q;
      pos_q   <= held_pos_q;
      cross_q <= cross_d;
      track_q <= one_line && !edge_lo_q && !edge_hi_q;
    end
  end

  assign result_o.valid               = out_valid_q;
  assign result_o.left_speed          = left_q;
  assign result_o.right_speed         = right_q;
  assign result_o.line_count          = count_q;
  assign result_o.first_line_position = pos_q;
  assign result_o.cross_type          = cross_q;
  assign result_o.on_track            = track_q;

endmodule

/* bench/tb_line_sensor_pd_steering_core.sv */
// Testbench for line_sensor_pd_steering_core: directed sensor rows, then randomized phases
// under changing register settings, checked against typed-in answers or an in-bench steering predictor.
// Depends on lsps_pkg, lsps_if.sv and the core RTL.
`timescale 1ns / 100ps

module tb_line_sensor_pd_steering_core;
  import lsps_pkg::*;

  localparam int SENSOR_N        = SENSOR_COUNT_DEF;
  localparam int CFG_REG_COUNT   = int'(CFG_HOLD_THRESH) + 1;
  // Index past the register list; the core must drop writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam int DIRECTED_N      = 24;
  localparam int PHASES          = 10;
  localparam int ROWS_PER_PHASE  = 45;
  localparam int PH_LONG_HOLD    = 4;   // receiver holds off, sender keeps offering
  localparam int PH_MID_PAUSE    = 6;   // sender waits for every result mid-phase
  localparam int LONG_HOLD_CYC   = 300;
  // Give the tail twice the length of the worst row.
  localparam int TAIL_CYC        = 2 * (SENSOR_N + 17);
  localparam int CYCLE_LIMIT     = 500_000;
  localparam int PRINT_CAP       = 40;

  // One steering result as seen on the result channel.
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [2:0]         count;
    logic [6:0]         pos;
    cross_e             cross_kind;
    logic               on_track;
  } steer_result_t;

  // Directed row: the sensor byte and, where it is obvious, the typed-in answer.
  typedef struct packed {
    logic [7:0]    bits;
    logic          typed;
    steer_result_t want;
  } steer_row_t;

  logic clk_i = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lsps_sensor_if #(.N(SENSOR_N)) sensor_ch ();
  lsps_result_if                 result_ch ();

  line_sensor_pd_steering_core #(
    .SENSOR_COUNT(SENSOR_N)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .sensor_i    (sensor_ch),
    .result_o    (result_ch)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and controller state, all at reset values.
  // ---------------------------------------------------------------------------
  logic [7:0] reg_base        = BASE_SPEED_RST;
  logic [7:0] reg_fb_left     = FALLBACK_LEFT_RST;
  logic [7:0] reg_fb_right    = FALLBACK_RIGHT_RST;
  logic [7:0] reg_p_gain      = P_GAIN_RST;
  logic [7:0] reg_d_gain      = D_GAIN_RST;
  logic [6:0] reg_setpoint    = SETPOINT_RST;
  logic [7:0] reg_hold_thresh = HOLD_THRESH_RST;

  logic [6:0] held_pos   = '0;
  int         prev_err   = 0;
  int         held_dterm = 0;
  logic [7:0] step_cnt   = '0;

  steer_result_t due_results[$];   // results still owed by the core, oldest first
  steer_row_t    row_tags[$];      // per offered row: typed answer or not
  int            mismatches = 0;
  int            cycle_count = 0;

  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  bit long_hold_req = 1'b0;

  function automatic int sat16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Runs the controller for one sensor row and advances the predictor state.
  function automatic steer_result_t predict_steer(input logic [7:0] row);
    int            runs;
    int            sum;
    int            len;
    int            first_pos;
    bit            found;
    bit            set;
    int            err;
    int            steer;
    logic [7:0]    old_cnt;
    bit            lo_edge;
    bit            hi_edge;
    steer_result_t res;
    runs = 0;
    sum = 0;
    len = 0;
    first_pos = 0;
    found = 1'b0;
    // Walk one past the top sensor so a run touching the edge is closed.
    for (int i = 0; i <= SENSOR_N; i++) begin
      set = (i < SENSOR_N) ? row[i] : 1'b0;
      if (set) begin
        sum += i;
        len++;
      end else if (len != 0) begin
        if (!found) begin
          first_pos = (sum * 10) / len;
          found = 1'b1;
        end
        if (runs < 7) runs++;
        sum = 0;
        len = 0;
      end
    end
    if (found) held_pos = (first_pos > 127) ? 7'd127 : first_pos[6:0];

    // Error runs every row, on the held position when no line is seen.
    err = int'(held_pos) - int'(reg_setpoint);
    old_cnt = step_cnt;
    step_cnt = step_cnt + 8'd1;
    if (old_cnt > reg_hold_thresh) begin
      step_cnt = '0;
      held_dterm = int'(reg_d_gain) * (err - prev_err);
      prev_err = err;
    end

    if (runs == 1) begin
      steer = int'(reg_p_gain) * err + held_dterm;
      res.left  = 16'(sat16(int'(reg_base) - steer));
      res.right = 16'(sat16(int'(reg_base) + steer));
    end else begin
      res.left  = 16'(reg_fb_left);
      res.right = 16'(reg_fb_right);
    end

    lo_edge = row[0];
    hi_edge = row[SENSOR_N-1];
    res.cross_kind = CROSS_ERROR;
    if (runs == 1) begin
      if (lo_edge && hi_edge) res.cross_kind = CROSS_T;
      else if (lo_edge)       res.cross_kind = CROSS_RIGHT;
      else if (hi_edge)       res.cross_kind = CROSS_LEFT;
    end
    res.on_track = (runs == 1) && !lo_edge && !hi_edge;
    res.count = runs[2:0];
    res.pos = held_pos;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  task automatic check_result(input steer_result_t got, input steer_result_t want);
    if (got.left !== want.left)         report_mismatch("left_speed", got.left, want.left);
    if (got.right !== want.right)       report_mismatch("right_speed", got.right, want.right);
    if (got.count !== want.count)       report_mismatch("line_count", got.count, want.count);
    if (got.pos !== want.pos)           report_mismatch("first_line_position", got.pos, want.pos);
    if (got.cross_kind !== want.cross_kind)
      report_mismatch("cross_type", got.cross_kind, want.cross_kind);
    if (got.on_track !== want.on_track) report_mismatch("on_track", got.on_track, want.on_track);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: register writes update the copies, a row transfer queues the
  // predicted (or typed) result, a result transfer is checked against the
  // oldest queued one. All values read here are the ones sampled at the edge.
  // ---------------------------------------------------------------------------
  steer_row_t    mon_tag;
  steer_result_t mon_pred;
  steer_result_t mon_got;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_BASE_SPEED:     reg_base        = cfg_wdata;
          CFG_FALLBACK_LEFT:  reg_fb_left     = cfg_wdata;
          CFG_FALLBACK_RIGHT: reg_fb_right    = cfg_wdata;
          CFG_P_GAIN:         reg_p_gain      = cfg_wdata;
          CFG_D_GAIN:         reg_d_gain      = cfg_wdata;
          CFG_SETPOINT:       reg_setpoint    = cfg_wdata[6:0];
          CFG_HOLD_THRESH:    reg_hold_thresh = cfg_wdata;
          default: ;          // unknown index: dropped
        endcase
      end

      if (sensor_ch.valid && sensor_ch.ready) begin
        mon_tag = row_tags.pop_front();
        mon_pred = predict_steer(sensor_ch.sensor_bits);
        due_results.push_back(mon_tag.typed ? mon_tag.want : mon_pred);
      end

      if (result_ch.valid && result_ch.ready) begin
        mon_got.left       = result_ch.left_speed;
        mon_got.right      = result_ch.right_speed;
        mon_got.count      = result_ch.line_count;
        mon_got.pos        = result_ch.first_line_position;
        mon_got.cross_kind = cross_e'(result_ch.cross_type);
        mon_got.on_track   = result_ch.on_track;
        if (due_results.size() == 0) report_mismatch("result with nothing due", 0, 0);
        else check_result(mon_got, due_results.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request so the core's
  // output register fills and the sensor side backs up.
  // ---------------------------------------------------------------------------
  int rx_gap;

  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYC) @(posedge clk_i);
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        rx_gap = pick_gap();
        if (rx_gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (rx_gap) @(posedge clk_i);
        end
      end
      result_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Hard stop on a hang.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one row and hold it until the transfer. Valid stays high afterward so
  // a back-to-back row needs no drop.
  task automatic offer_row(input logic [7:0] bits, input logic typed, input steer_result_t want);
    row_tags.push_back('{bits, typed, want});
    sensor_ch.valid       <= 1'b1;
    sensor_ch.sensor_bits <= bits;
    do @(posedge clk_i); while (!sensor_ch.ready);
  endtask

  task automatic sender_gap();
    int n;
    n = tx_gaps_on ? pick_gap() : 0;
    if (n > 0) begin
      sensor_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic drain_results();
    sensor_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Directed rows, all under reset register values. The D term stays zero here
  // (too few rows to pass the hold threshold), so typed answers are base -/+ 4*e.
  steer_row_t directed_rows [DIRECTED_N] = '{
    '{8'h00, 1'b1, '{76, 60, 3'd0, 7'd0, CROSS_ERROR, 1'b0}},   // nothing seen, reset position
    '{8'hFF, 1'b1, '{90, 90, 3'd1, 7'd35, CROSS_T, 1'b0}},      // full row: T junction
    '{8'h01, 1'b1, '{230, -50, 3'd1, 7'd0, CROSS_RIGHT, 1'b0}}, // lowest edge only
    '{8'h80, 1'b1, '{-50, 230, 3'd1, 7'd70, CROSS_LEFT, 1'b0}}, // highest edge only
    '{8'h00, 1'b1, '{76, 60, 3'd0, 7'd70, CROSS_ERROR, 1'b0}},  // position held
    '{8'h18, 1'b1, '{90, 90, 3'd1, 7'd35, CROSS_ERROR, 1'b1}},  // centered, on track
    '{8'h55, 1'b1, '{76, 60, 3'd4, 7'd0, CROSS_ERROR, 1'b0}},   // most runs possible
    '{8'hAA, 1'b1, '{76, 60, 3'd4, 7'd10, CROSS_ERROR, 1'b0}},
    '{8'h81, 1'b1, '{76, 60, 3'd2, 7'd0, CROSS_ERROR, 1'b0}},   // both edges, two runs
    '{8'h06, 1'b1, '{170, 10, 3'd1, 7'd15, CROSS_ERROR, 1'b1}},
    '{8'hFE, 1'b1, '{70, 110, 3'd1, 7'd40, CROSS_LEFT, 1'b0}},
    '{8'h7F, 1'b1, '{110, 70, 3'd1, 7'd30, CROSS_RIGHT, 1'b0}},
    '{8'h03, 1'b0, '0},
    '{8'hC0, 1'b0, '0},
    '{8'h3C, 1'b0, '0},
    '{8'h0F, 1'b0, '0},
    '{8'hF0, 1'b0, '0},
    '{8'h24, 1'b0, '0},
    '{8'h42, 1'b0, '0},
    '{8'h99, 1'b0, '0},
    '{8'h10, 1'b0, '0},
    '{8'h08, 1'b0, '0},
    '{8'hE7, 1'b0, '0},
    '{8'h00, 1'b0, '0}
  };

  logic [7:0] phase_cfg [CFG_REG_COUNT];
  logic [7:0] rand_row;
  int         run_start;
  int         run_len;
  int         pick;

  initial begin
    rst_n                 = 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= '0;
    cfg_wdata             <= '0;
    sensor_ch.valid       <= 1'b0;
    sensor_ch.sensor_bits <= '0;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_row(directed_rows[i].bits, directed_rows[i].typed, directed_rows[i].want);
      sender_gap();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // Registers only change with the core idle.
      drain_results();
      case (ph)
        0: foreach (phase_cfg[i]) phase_cfg[i] = 8'hFF;   // setpoint masks to 127, D frozen
        1: foreach (phase_cfg[i]) phase_cfg[i] = 8'h00;   // D refreshed every other row
        2: begin                                         // drive speeds into saturation
          phase_cfg[CFG_BASE_SPEED]     = 8'h00;
          phase_cfg[CFG_FALLBACK_LEFT]  = 8'h00;
          phase_cfg[CFG_FALLBACK_RIGHT] = 8'hFF;
          phase_cfg[CFG_P_GAIN]         = 8'hFF;
          phase_cfg[CFG_D_GAIN]         = 8'hFF;
          phase_cfg[CFG_SETPOINT]       = 8'd0;
          phase_cfg[CFG_HOLD_THRESH]    = 8'd0;
        end
        3: begin
          phase_cfg[CFG_BASE_SPEED]     = 8'hFF;
          phase_cfg[CFG_FALLBACK_LEFT]  = 8'hFF;
          phase_cfg[CFG_FALLBACK_RIGHT] = 8'h00;
          phase_cfg[CFG_P_GAIN]         = 8'hFF;
          phase_cfg[CFG_D_GAIN]         = 8'hFF;
          phase_cfg[CFG_SETPOINT]       = 8'd70;
          phase_cfg[CFG_HOLD_THRESH]    = 8'd1;
        end
        default: begin
          foreach (phase_cfg[i]) phase_cfg[i] = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) != 0) phase_cfg[CFG_SETPOINT] = 8'($urandom_range(0, 70));
          // Short hold periods mostly, so the D term moves within a phase.
          if ($urandom_range(0, 4) != 0) phase_cfg[CFG_HOLD_THRESH] = 8'($urandom_range(0, 6));
        end
      endcase
      for (int i = 0; i < CFG_REG_COUNT; i++) write_reg(i[CFG_IDX_W-1:0], phase_cfg[i]);
      if (ph == 1) write_reg(CFG_IDX_SPARE, 8'($urandom_range(0, 255)));
      cfg_we <= 1'b0;

      // Some phases run without gaps on one side or the other.
      tx_gaps_on   = (ph % 3 != 2) && (ph != PH_LONG_HOLD);
      rx_stalls_on = (ph % 4 != 3);
      if (ph == PH_LONG_HOLD) long_hold_req = 1'b1;

      for (int k = 0; k < ROWS_PER_PHASE; k++) begin
        if (ph == PH_MID_PAUSE && k == ROWS_PER_PHASE / 2) drain_results();
        // Mostly a single line (the steering path), some empty rows, rest noise.
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          run_start = $urandom_range(0, SENSOR_N - 1);
          run_len   = $urandom_range(1, SENSOR_N - run_start);
          rand_row  = 8'(((1 << run_len) - 1) << run_start);
        end else if (pick < 65) begin
          rand_row = '0;
        end else begin
          rand_row = 8'($urandom_range(0, 255));
        end
        offer_row(rand_row, 1'b0, '0);
        sender_gap();
      end
    end

    drain_results();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (due_results.size() != 0) report_mismatch("results never delivered", due_results.size(), 0);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lsps_pkg.sv
hw/rtl/lsps_if.sv
hw/rtl/lsps_useq.sv
hw/rtl/line_sensor_pd_steering_core.sv
bench/tb_line_sensor_pd_steering_core.sv
